// ===== hw/rtl/gid_pkg.sv =====
// ----------------------------------------------------------------------------
// gid_pkg
// Shared constants and types for the grouped input debouncer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gid_pkg;

  localparam int unsigned LANES           = 8;   // inputs per group
  localparam int unsigned GIDX_W          = 4;
  localparam int unsigned GIDX_N          = 1 << GIDX_W;
  localparam int unsigned TIME_W          = 16;
  localparam int unsigned GROUP_COUNT_DEF = 16;
  localparam int unsigned COUNT_W_DEF     = 16;

  // Per-bit status carried between a lane and the merge logic
  typedef struct packed {
    logic level;
    logic mark;
  } lane_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/grouped_input_debouncer_top.sv =====
// ----------------------------------------------------------------------------
// grouped_input_debouncer_top
// Datapath: the RAM read is registered with stage 1 at input accept, and the
// lane update is loaded into the output register when stage 1 advances.
// Throughput: one word per cycle while the output is not stalled, set by the
// group state RAM with a write-to-read bypass of the last written row.
// Reset: asynchronous, clears control and the per-group valid bits at once;
// a group never written reads as all zero. No clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grouped_input_debouncer_top #(
  parameter int unsigned GroupCount = gid_pkg::GROUP_COUNT_DEF,
  parameter int unsigned CountWidth = gid_pkg::COUNT_W_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [gid_pkg::GIDX_W-1:0]   group_index_i,
  input  wire logic [gid_pkg::LANES-1:0]    raw_inputs_i,
  input  wire logic [gid_pkg::TIME_W-1:0]   debounce_time_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [gid_pkg::LANES-1:0]    debounced_levels_o,
  output logic      [gid_pkg::LANES-1:0]    chatter_flags_o
);

  import gid_pkg::*;

  localparam int unsigned GrpW     = (GroupCount > 1) ? $clog2(GroupCount) : 1;
  localparam int unsigned LaneRowW = 2 * CountWidth;
  localparam int unsigned CntBase  = 3 * LANES;
  localparam int unsigned RowW     = CntBase + LANES * LaneRowW;

  // group index folded into range
  logic [GrpW-1:0] grp_map [GIDX_N];

  for (genvar i = 0; i < GIDX_N; i++) begin : g_map
    assign grp_map[i] = GrpW'(i % GroupCount);
  end

  logic                  in_acc;
  logic                  s1_adv;
  logic [GrpW-1:0]       in_grp;

  logic                  s1_valid_q;
  logic [GrpW-1:0]       s1_grp_q;
  logic [LANES-1:0]      s1_raw_q;
  logic [TIME_W-1:0]     s1_time_q;
  logic                  fwd_q;
  logic [RowW-1:0]       last_row_q;
  logic [GroupCount-1:0] grp_vld_q;

  logic                  out_valid_q;
  logic                  out_valid_d;
  logic [LANES-1:0]      out_lvl_q;
  logic [LANES-1:0]      out_chat_q;

  logic [RowW-1:0]       rd_row;
  logic [RowW-1:0]       row_cur;
  logic [RowW-1:0]       row_new;
  logic [TIME_W-1:0]     settle;
  logic [LANES-1:0]      prev_smp;
  logic [LANES-1:0]      changed;
  logic [LANES-1:0]      lvl_new;
  logic [LANES-1:0]      mark_new;

  assign in_grp     = grp_map[group_index_i];
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  gid_ram #(
    .Width (RowW),
    .Depth (GroupCount)
  ) u_state_ram (
    .clk_i     (clk_i),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_grp_q),
    .wr_data_i (row_new),
    .rd_en_i   (in_acc),
    .rd_addr_i (in_grp),
    .rd_data_o (rd_row)
  );

  // bypass the row written in the same cycle the read was issued
  assign row_cur  = fwd_q ? last_row_q : (grp_vld_q[s1_grp_q] ? rd_row : '0);
  assign settle   = (s1_time_q == '0) ? TIME_W'(1) : s1_time_q;
  assign prev_smp = row_cur[LANES-1:0];
  assign changed  = s1_raw_q ^ prev_smp;

  for (genvar b = 0; b < LANES; b++) begin : g_lane
    lane_flags_t           flags_cur;
    lane_flags_t           flags_nxt;
    logic [CountWidth-1:0] stable_nxt;
    logic [CountWidth-1:0] toggle_nxt;

    assign flags_cur.level = row_cur[LANES + b];
    assign flags_cur.mark  = row_cur[2*LANES + b];

    gid_lane #(
      .CountWidth (CountWidth)
    ) u_lane (
      .changed_i (changed[b]),
      .sample_i  (s1_raw_q[b]),
      .settle_i  (settle),
      .flags_i   (flags_cur),
      .stable_i  (row_cur[CntBase + b*LaneRowW +: CountWidth]),
      .toggle_i  (row_cur[CntBase + b*LaneRowW + CountWidth +: CountWidth]),
      .flags_o   (flags_nxt),
      .stable_o  (stable_nxt),
      .toggle_o  (toggle_nxt)
    );

    assign lvl_new[b]  = flags_nxt.level;
    assign mark_new[b] = flags_nxt.mark;
    assign row_new[CntBase + b*LaneRowW +: CountWidth]              = stable_nxt;
    assign row_new[CntBase + b*LaneRowW + CountWidth +: CountWidth] = toggle_nxt;
  end

  // merge lane results into the group row
  assign row_new[LANES-1:0]         = s1_raw_q;
  assign row_new[2*LANES-1:LANES]   = lvl_new;
  assign row_new[3*LANES-1:2*LANES] = mark_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      grp_vld_q  <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_adv && (in_grp == s1_grp_q);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        grp_vld_q[s1_grp_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_grp_q  <= in_grp;
      s1_raw_q  <= raw_inputs_i;
      s1_time_q <= debounce_time_i;
    end
    if (s1_adv) begin
      last_row_q <= row_new;
      out_lvl_q  <= lvl_new;
      out_chat_q <= mark_new;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign debounced_levels_o = out_lvl_q;
  assign chatter_flags_o    = out_chat_q;

`ifndef NO_ASSERTIONS
  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("word left stage 1 but output register is empty");

  a_adv_marks_grp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> grp_vld_q[$past(s1_grp_q)])
    else $error("written group not marked valid");

  a_acc_loads_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted word missing from stage 1");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |=> (s1_valid_q && $stable(s1_grp_q)))
    else $error("stage 1 word lost during output stall");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/gid_ram.sv =====
// ----------------------------------------------------------------------------
// gid_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gid_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gid_lane.sv =====
// ----------------------------------------------------------------------------
// gid_lane
// Debounce update of one input bit: stable and toggle counters, level and
// chatter mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gid_lane #(
  parameter int unsigned CountWidth = 16
) (
  input  wire logic                        changed_i,
  input  wire logic                        sample_i,
  input  wire logic [gid_pkg::TIME_W-1:0]  settle_i,   // never zero
  input  wire gid_pkg::lane_flags_t        flags_i,
  input  wire logic [CountWidth-1:0]       stable_i,
  input  wire logic [CountWidth-1:0]       toggle_i,
  output gid_pkg::lane_flags_t             flags_o,
  output logic      [CountWidth-1:0]       stable_o,
  output logic      [CountWidth-1:0]       toggle_o
);

  import gid_pkg::*;

  localparam int unsigned CmpW = (CountWidth > TIME_W) ? CountWidth : TIME_W;

  logic [CountWidth-1:0] stable_inc;
  logic [CountWidth-1:0] toggle_inc;
  logic [CmpW-1:0]       settle_ext;
  logic [CmpW-1:0]       accept_thr;

  // saturating increments
  assign stable_inc = (stable_i == '1) ? stable_i : stable_i + CountWidth'(1);
  assign toggle_inc = (toggle_i == '1) ? toggle_i : toggle_i + CountWidth'(1);
  assign settle_ext = CmpW'(settle_i);
  assign accept_thr = settle_ext - CmpW'(1);

  always_comb begin
    flags_o  = flags_i;
    stable_o = stable_i;
    toggle_o = toggle_i;
    if (changed_i) begin
      stable_o = '0;
      if (CmpW'(toggle_inc) >= settle_ext) begin
        // only reachable when settle fits in the counter
        toggle_o      = CountWidth'(settle_ext);
        flags_o.mark  = 1'b1;
      end else begin
        toggle_o      = toggle_inc;
        flags_o.mark  = 1'b0;
      end
    end else begin
      toggle_o = '0;
      if (CmpW'(stable_inc) >= accept_thr) begin
        flags_o.level = sample_i;
        stable_o      = stable_i;   // count held once accepted
      end else begin
        stable_o      = stable_inc;
      end
    end
  end

endmodule

`default_nettype wire
